FILE: sv/fps_pkg.sv
package fps_pkg;

  // Port-level widths fixed by the stream and register formats
  localparam int PORT_COORD_W = 16;
  localparam int S_TDATA_W    = 48;
  localparam int INDEX_W      = 10;
  localparam int M_TDATA_W    = 16;
  localparam int SAMPLE_W     = 7;
  localparam int ADDR_W       = 3;
  localparam int DATA_W       = 32;

  localparam logic [SAMPLE_W-1:0] MAX_SAMPLES  = 7'd64;
  localparam logic [SAMPLE_W-1:0] SAMPLE_RESET = 7'd16;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_COUNT = 1'b0;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage

FILE: sv/fps_cell.sv
module fps_cell #(
  parameter int COORD_BITS = 16,
  parameter int IDX_W = 10,
  localparam int DIST_W = 2 * COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load_ref,
  input  logic [COORD_BITS-1:0]        ref_in,
  input  fps_pkg::ctl_t                in_ctl,
  input  logic [IDX_W-1:0]             in_idx,
  input  logic [2:0][COORD_BITS-1:0]   in_pt,
  input  logic [DIST_W-1:0]            in_sum,
  output fps_pkg::ctl_t                out_ctl,
  output logic [IDX_W-1:0]             out_idx,
  output logic [2:0][COORD_BITS-1:0]   out_pt,
  output logic [DIST_W-1:0]            out_sum
);
  import fps_pkg::*;

  logic [COORD_BITS-1:0]          ref_coord;
  ctl_t                           a_ctl;
  logic [IDX_W-1:0]               a_idx;
  logic [2:0][COORD_BITS-1:0]     a_pt;
  logic [DIST_W-1:0]              a_sum;
  logic signed [COORD_BITS:0]     a_diff;
  logic signed [COORD_BITS:0]     diff;
  logic signed [2*COORD_BITS+1:0] sq;

  // this cell always works on lane 0; lanes rotate so the next cell sees the next axis
  assign diff = $signed({in_pt[0][COORD_BITS-1], in_pt[0]})
              - $signed({ref_coord[COORD_BITS-1], ref_coord});
  assign sq = a_diff * a_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl   <= '0;
      out_ctl <= '0;
    end else begin
      a_ctl   <= in_ctl;
      out_ctl <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ref) begin
      ref_coord <= ref_in;
    end
    a_idx   <= in_idx;
    a_pt    <= {in_pt[0], in_pt[2], in_pt[1]};
    a_sum   <= in_sum;
    a_diff  <= diff;
    out_idx <= a_idx;
    out_pt  <= a_pt;
    out_sum <= a_sum + DIST_W'($unsigned(sq));
  end

endmodule

FILE: sv/fps_select.sv
module fps_select #(
  parameter int COORD_BITS = 16,
  parameter int MAX_POINTS = 1024,
  localparam int DIST_W = 2 * COORD_BITS + 3,
  localparam int IDX_W = $clog2(MAX_POINTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       first_round,
  input  fps_pkg::ctl_t              in_ctl,
  input  logic [IDX_W-1:0]           in_idx,
  input  logic [2:0][COORD_BITS-1:0] in_pt,
  input  logic [DIST_W-1:0]          in_sum,
  output logic                       done,
  output logic [IDX_W-1:0]           best_idx,
  output logic [2:0][COORD_BITS-1:0] best_pt
);
  import fps_pkg::*;

  logic [DIST_W-1:0]          min_mem [MAX_POINTS];
  ctl_t                       a_ctl;
  logic [IDX_W-1:0]           a_idx;
  logic [2:0][COORD_BITS-1:0] a_pt;
  logic [DIST_W-1:0]          a_sum;
  logic [DIST_W-1:0]          min_rd;
  logic [DIST_W-1:0]          new_min;
  logic [DIST_W-1:0]          best_d;
  logic                       take;

  // the first round of a run sees every stored minimum as all ones
  assign new_min = (first_round || (a_sum < min_rd)) ? a_sum : min_rd;
  assign take    = (a_idx == '0) || (new_min > best_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
      done  <= 1'b0;
    end else begin
      a_ctl <= in_ctl;
      done  <= a_ctl.valid && a_ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    a_idx  <= in_idx;
    a_pt   <= in_pt;
    a_sum  <= in_sum;
    min_rd <= min_mem[in_idx];
    if (a_ctl.valid) begin
      min_mem[a_idx] <= new_min;
      if (take) begin
        best_d   <= new_min;
        best_idx <= a_idx;
        best_pt  <= a_pt;
      end
    end
  end

endmodule

FILE: sv/farthest_point_sampler_unit.sv
// Farthest point sampler. Points stream in on the slave side at one item per
// cycle and are written to the point memory; tlast closes the cloud. The first
// result is index 0 and is ready in the cycle after the closing item. Each
// further result takes one sweep over the n loaded points: a read of the point
// memory, a chain of three cells (one per axis) that subtract the reference
// point, square and accumulate, then a stage that lowers the stored minimum
// and keeps the running argmax. No points are accepted until the last result
// of the run has been loaded into the output register.
module farthest_point_sampler_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: point_x [15:0], point_y [31:16], point_z [47:32]
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fps_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  // m_tdata: sample_index [9:0], zero fill above
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fps_pkg::M_TDATA_W-1:0] m_tdata,
  output logic                          m_tlast,
  // m_tuser: overflow
  output logic                          m_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fps_pkg::ADDR_W-1:0]    paddr,
  input  logic [fps_pkg::DATA_W-1:0]    pwdata,
  output logic [fps_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import fps_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIST_W = 2 * COORD_BITS + 3;

  state_t                      state;
  logic [SAMPLE_W-1:0]         sample_count;
  logic [SAMPLE_W-1:0]         count_sat;
  logic [SAMPLE_W-1:0]         run_count;
  logic [SAMPLE_W-1:0]         k;
  logic [CNT_W-1:0]            loaded_count;
  logic [CNT_W-1:0]            close_n;
  logic [CNT_W-1:0]            run_n;
  logic [CNT_W-1:0]            n_minus1;
  logic [IDX_W-1:0]            last_idx;
  logic [IDX_W-1:0]            scan_idx;
  logic                        overflow_seen;
  logic                        run_ovf;
  logic                        issuing;
  logic                        in_fire;
  logic                        has_room;
  logic                        result_ready;
  logic                        out_free;
  logic                        emit;
  logic                        res_last;
  logic                        load_ref;
  logic                        first_round;
  logic                        cfg_we;
  logic [IDX_W-1:0]            res_idx;
  logic [IDX_W+INDEX_W-1:0]    res_idx_ext;
  logic [INDEX_W-1:0]          m_idx;

  logic [2:0][COORD_BITS-1:0]  in_coords;
  logic [2:0][COORD_BITS-1:0]  p0;
  logic [2:0][COORD_BITS-1:0]  ref_pt;
  logic [2:0][COORD_BITS-1:0]  point_mem [MAX_POINTS];

  ctl_t                        ch_ctl [4];
  logic [IDX_W-1:0]            ch_idx [4];
  logic [2:0][COORD_BITS-1:0]  ch_pt  [4];
  logic [DIST_W-1:0]           ch_sum [4];

  logic                        sel_done;
  logic [IDX_W-1:0]            sel_best_idx;
  logic [2:0][COORD_BITS-1:0]  sel_best_pt;

  // coordinates: low COORD_BITS of the 16-bit field, zero filled when wider
  genvar g;
  generate
    for (g = 0; g < 3; g++) begin : g_coord
      logic [COORD_BITS+PORT_COORD_W-1:0] wide;
      assign wide         = {{COORD_BITS{1'b0}}, s_tdata[g*PORT_COORD_W +: PORT_COORD_W]};
      assign in_coords[g] = wide[COORD_BITS-1:0];
    end
  endgenerate

  assign s_tready     = (state == ST_LOAD);
  assign in_fire      = s_tvalid && s_tready;
  assign has_room     = loaded_count < CNT_W'(MAX_POINTS);
  assign close_n      = has_room ? loaded_count + CNT_W'(1) : loaded_count;
  assign count_sat    = (sample_count > MAX_SAMPLES) ? MAX_SAMPLES : sample_count;
  assign n_minus1     = run_n - CNT_W'(1);
  assign last_idx     = n_minus1[IDX_W-1:0];

  assign result_ready = (state == ST_HOLD) || ((state == ST_SCAN) && sel_done);
  assign out_free     = !m_tvalid || m_tready;
  assign emit         = result_ready && out_free;
  assign res_last     = (k + SAMPLE_W'(1)) == run_count;
  assign res_idx      = (k == '0) ? '0 : sel_best_idx;
  assign res_idx_ext  = {{INDEX_W{1'b0}}, res_idx};
  assign ref_pt       = (k == '0) ? p0 : sel_best_pt;
  assign load_ref     = emit && !res_last;
  assign first_round  = (k == SAMPLE_W'(1));

  // config port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_SAMPLE_COUNT)
                ? {{(DATA_W-SAMPLE_W){1'b0}}, sample_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= SAMPLE_RESET;
    end else if (cfg_we && (paddr[2] == REG_SAMPLE_COUNT)) begin
      sample_count <= pwdata[SAMPLE_W-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      loaded_count  <= '0;
      overflow_seen <= 1'b0;
      run_n         <= '0;
      run_count     <= '0;
      run_ovf       <= 1'b0;
      k             <= '0;
      issuing       <= 1'b0;
      scan_idx      <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (issuing) begin
        if (scan_idx == last_idx) begin
          issuing <= 1'b0;
        end else begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end

      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_LOAD: begin
          if (in_fire) begin
            if (s_tlast) begin
              loaded_count  <= '0;
              overflow_seen <= 1'b0;
              run_n         <= close_n;
              run_ovf       <= overflow_seen || !has_room;
              run_count     <= count_sat;
              k             <= '0;
              if (count_sat != '0) begin
                state <= ST_HOLD;
              end
            end else if (has_room) begin
              loaded_count <= loaded_count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
        end
        ST_SCAN, ST_HOLD: begin
          if (emit) begin
            if (res_last) begin
              state <= ST_LOAD;
            end else begin
              state    <= ST_SCAN;
              k        <= k + SAMPLE_W'(1);
              issuing  <= 1'b1;
              scan_idx <= '0;
            end
          end else if (result_ready) begin
            state <= ST_HOLD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_idx   <= res_idx_ext[INDEX_W-1:0];
      m_tlast <= res_last;
      m_tuser <= run_ovf;
    end
  end

  assign m_tdata = {{(M_TDATA_W-INDEX_W){1'b0}}, m_idx};

  // point memory and first pipeline stage
  always_ff @(posedge clk) begin
    if (in_fire && has_room) begin
      point_mem[loaded_count[IDX_W-1:0]] <= in_coords;
    end
    if (in_fire && (loaded_count == '0)) begin
      p0 <= in_coords;
    end
    ch_pt[0]  <= point_mem[scan_idx];
    ch_idx[0] <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_ctl[0] <= '0;
    end else begin
      ch_ctl[0].valid <= issuing;
      ch_ctl[0].last  <= (scan_idx == last_idx);
    end
  end

  assign ch_sum[0] = '0;

  generate
    for (g = 0; g < 3; g++) begin : g_cell
      fps_cell #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .load_ref (load_ref),
        .ref_in   (ref_pt[g]),
        .in_ctl   (ch_ctl[g]),
        .in_idx   (ch_idx[g]),
        .in_pt    (ch_pt[g]),
        .in_sum   (ch_sum[g]),
        .out_ctl  (ch_ctl[g+1]),
        .out_idx  (ch_idx[g+1]),
        .out_pt   (ch_pt[g+1]),
        .out_sum  (ch_sum[g+1])
      );
    end
  endgenerate

  fps_select #(
    .COORD_BITS (COORD_BITS),
    .MAX_POINTS (MAX_POINTS)
  ) u_select (
    .clk         (clk),
    .rst         (rst),
    .first_round (first_round),
    .in_ctl      (ch_ctl[3]),
    .in_idx      (ch_idx[3]),
    .in_pt       (ch_pt[3]),
    .in_sum      (ch_sum[3]),
    .done        (sel_done),
    .best_idx    (sel_best_idx),
    .best_pt     (sel_best_pt)
  );

  // a sweep only ends inside a scan round
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    sel_done |-> (state == ST_SCAN))
    else $error("sweep finished outside a scan round");

  a_issue_in_scan: assert property (@(posedge clk) disable iff (rst)
    issuing |-> (state == ST_SCAN))
    else $error("point reads issued outside a scan round");

  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_LOAD) |-> (k < run_count))
    else $error("round counter ran past the sample count");

  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s_tlast && (count_sat != '0)) |=> !s_tready)
    else $error("points accepted after a cloud closed");

endmodule

FILE: dv/tb_farthest_point_sampler_unit.sv
`timescale 1ns / 1ps

module tb_farthest_point_sampler_unit;
  import fps_pkg::*;

  localparam int CLOUD_CAP      = 1024;
  localparam int DIST_W         = 2 * PORT_COORD_W + 3;
  localparam int STALL_MAX      = 11;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_ITEMS   = 400;

  typedef logic signed [PORT_COORD_W-1:0] coord_t;

  localparam coord_t COORD_MIN = 16'sh8000;
  localparam coord_t COORD_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               last;
    logic               overflow;
  } sample_t;

  typedef enum {CLOUD_WIDE, CLOUD_TIGHT, CLOUD_CORNERS} cloud_kind_t;

  class fps_scoreboard;
    coord_t              px[CLOUD_CAP];
    coord_t              py[CLOUD_CAP];
    coord_t              pz[CLOUD_CAP];
    logic [DIST_W-1:0]   min_dist[CLOUD_CAP];
    int unsigned         held;
    bit                  dropped;
    logic [SAMPLE_W-1:0] sample_count;
    sample_t             pending[$];
    int                  errors;
    int                  results;
    int                  clouds;
    int                  overflow_clouds;

    function new();
      held = 0;
      dropped = 0;
      sample_count = SAMPLE_RESET;
      errors = 0;
      results = 0;
      clouds = 0;
      overflow_clouds = 0;
    endfunction

    function void report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endfunction

    function logic [DIST_W-1:0] sq_dist(int unsigned a, int unsigned b);
      longint dx, dy, dz;
      dx = longint'(px[a]) - longint'(px[b]);
      dy = longint'(py[a]) - longint'(py[b]);
      dz = longint'(pz[a]) - longint'(pz[b]);
      return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    // Stores one point; the closing point runs the whole sampling pass.
    function void note_point(coord_t x, coord_t y, coord_t z, logic closing);
      int unsigned       rounds, chosen, best;
      logic [DIST_W-1:0] best_d, d;
      sample_t           s;
      if (held < CLOUD_CAP) begin
        px[held] = x;
        py[held] = y;
        pz[held] = z;
        held++;
      end else begin
        dropped = 1'b1;
      end
      if (!closing) return;
      rounds = (sample_count > MAX_SAMPLES) ? MAX_SAMPLES : sample_count;
      for (int i = 0; i < held; i++) min_dist[i] = '1;
      chosen = 0;
      for (int k = 0; k < rounds; k++) begin
        if (k > 0 && held > 0) begin
          best = 0;
          best_d = '0;
          for (int i = 0; i < held; i++) begin
            d = sq_dist(chosen, i);
            if (d < min_dist[i]) min_dist[i] = d;
            // strict compare keeps the lowest index on ties
            if (i == 0 || min_dist[i] > best_d) begin
              best_d = min_dist[i];
              best = i;
            end
          end
          chosen = best;
        end
        s.index = INDEX_W'(chosen);
        s.last = (k + 1 == rounds);
        s.overflow = dropped;
        pending.push_back(s);
      end
      clouds++;
      if (dropped) overflow_clouds++;
      held = 0;
      dropped = 1'b0;
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] data, logic last, logic ovf);
      sample_t s;
      results++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected item, tdata 0x%0h", data));
        return;
      end
      s = pending.pop_front();
      if (data !== M_TDATA_W'(s.index))
        report($sformatf("sample_index 0x%0h, expected %0d", data, s.index));
      if (last !== s.last)
        report($sformatf("last_sample %b, expected %b (index %0d)", last, s.last, s.index));
      if (ovf !== s.overflow)
        report($sformatf("overflow %b, expected %b (index %0d)", ovf, s.overflow, s.index));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  fps_scoreboard scoreboard;
  bit            sink_busy = 1'b0;
  int            hold_left = 0;
  int            quiet_cycles = 0;
  int            points_sent = 0;

  farthest_point_sampler_unit uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int draw_wait(bit busy);
    return busy ? int'($urandom_range(0, STALL_MAX)) : 0;
  endfunction

  // Result side: check each item, then hold tready low for a drawn stall.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        scoreboard.check_result(m_tdata, m_tlast, m_tuser);
        hold_left = draw_wait(sink_busy);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("** farthest_point_sampler_unit: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_point(coord_t x, coord_t y, coord_t z, logic closing, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tlast  <= closing;
    do @(posedge clk); while (!s_tready);
    scoreboard.note_point(x, y, z, closing);
    points_sent++;
  endtask

  function automatic coord_t pick_coord(cloud_kind_t kind);
    case (kind)
      CLOUD_TIGHT: return coord_t'(int'($urandom_range(0, 2)) - 1);
      CLOUD_CORNERS: begin
        case ($urandom_range(0, 3))
          0:       return COORD_MIN;
          1:       return COORD_MAX;
          2:       return coord_t'(0);
          default: return coord_t'(-1);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_cloud(int n, cloud_kind_t kind, bit busy);
    for (int i = 0; i < n; i++)
      send_point(pick_coord(kind), pick_coord(kind), pick_coord(kind), i == n - 1,
                 draw_wait(busy));
  endtask

  // Holds off until every expected index is back, then lets the block settle.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (scoreboard.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sample_count(logic [SAMPLE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SAMPLE_COUNT, 2'b00};
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    scoreboard.sample_count = value;
  endtask

  initial begin
    int          random_start, clouds_in_phase;
    bit          src_busy;
    cloud_kind_t kind;
    scoreboard = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset count of 16 on a single point: every index is 0
    send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 0);
    // opposite corners, largest possible distance
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0, 0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 3);
    // equal distances and a duplicate point, ties go to the lowest index
    sink_busy = 1'b1;
    send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0, 0);
    send_point(coord_t'(100), coord_t'(0), coord_t'(0), 1'b0, 1);
    send_point(coord_t'(-100), coord_t'(0), coord_t'(0), 1'b0, 0);
    send_point(coord_t'(0), coord_t'(100), coord_t'(0), 1'b0, 2);
    send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1, 0);
    wait_drained();

    write_sample_count(7'd1);
    send_cloud(3, CLOUD_CORNERS, 1'b1);
    wait_drained();
    // more samples than points
    write_sample_count(7'd64);
    send_cloud(5, CLOUD_TIGHT, 1'b0);
    wait_drained();
    // saturates to 64
    write_sample_count(7'd127);
    send_cloud(3, CLOUD_WIDE, 1'b1);
    wait_drained();
    // zero samples: closing point emits nothing
    write_sample_count(7'd0);
    send_cloud(3, CLOUD_WIDE, 1'b0);
    wait_drained();
    // past capacity; the dropped closing point still starts sampling
    write_sample_count(7'd2);
    sink_busy = 1'b1;
    send_cloud(CLOUD_CAP + 3, CLOUD_WIDE, 1'b0);
    wait_drained();

    random_start = points_sent;
    while (points_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       write_sample_count(7'd1);
        1:       write_sample_count(7'd64);
        2:       write_sample_count(7'd127);
        3:       write_sample_count(7'd0);
        default: write_sample_count(SAMPLE_W'($urandom_range(1, 64)));
      endcase
      clouds_in_phase = $urandom_range(1, 4);
      for (int c = 0; c < clouds_in_phase; c++) begin
        src_busy  = ($urandom_range(0, 2) != 0);
        sink_busy = ($urandom_range(0, 2) != 0);
        kind = cloud_kind_t'($urandom_range(0, 2));
        send_cloud(($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 24), kind, src_busy);
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
      wait_drained();
    end

    if (scoreboard.pending.size() != 0)
      scoreboard.report($sformatf("%0d indices never arrived", scoreboard.pending.size()));
    $display("coverage: %0d points in %0d clouds (%0d past capacity), %0d indices checked",
             points_sent, scoreboard.clouds, scoreboard.overflow_clouds, scoreboard.results);
    $display("coverage: sample counts 0, 1, 64, 127 and random, with and without stalls");
    if (scoreboard.errors == 0) begin
      $display("** farthest_point_sampler_unit: PASSED **");
    end else begin
      $display("** farthest_point_sampler_unit: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/fps_pkg.sv
sv/fps_cell.sv
sv/fps_select.sv
sv/farthest_point_sampler_unit.sv
dv/tb_farthest_point_sampler_unit.sv
